FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to leave them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the segment region table.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int PAGE_BITS_DEF    = 10;
    localparam int ADDR_BITS_DEF    = 25;

    localparam int OP_W  = 2;
    localparam int ACC_W = 2;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Control part of the request token that walks along the cell row.
    typedef struct packed {
        logic             valid;
        logic [OP_W-1:0]  op;
        logic             trap;
        logic             found;
        logic [ACC_W-1:0] acc;
    } tok_t;

    // Commands broadcast to every cell when the token leaves the row.
    typedef struct packed {
        logic write;
        logic release_claim;
    } cmt_t;

endpackage

FILE: rtl/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds a segment and updates the passing request token.
// ----------------------------------------------------------------------------
module srt_cell
    import srt_pkg::*;
#(
    parameter int PAGE_W = ADDR_BITS_DEF - PAGE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tok_t              tok_in,
    input  logic [PAGE_W-1:0] page_in,
    output tok_t              tok_out,
    output logic [PAGE_W-1:0] page_out,
    input  logic [PAGE_W-1:0] req_page,
    input  logic [PAGE_W-1:0] req_end,
    input  logic [ACC_W-1:0]  req_acc,
    input  cmt_t              cmt,
    output logic              claimed
);

    logic              valid_reg;
    logic              valid_next;
    logic              claim_reg;
    logic              claim_next;
    logic [PAGE_W-1:0] start_reg;
    logic [PAGE_W-1:0] end_reg;
    logic [ACC_W-1:0]  acc_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              contains;
    logic              overlaps;

    // Page units suffice: a page-aligned bound compares with the probe's page.
    assign contains = valid_reg && (start_reg <= req_page) && (end_reg > req_page);
    assign overlaps = contains ||
                      (valid_reg && (req_page <= start_reg) && (req_end > start_reg));

    always_comb
    begin
        tok_next   = tok_in;
        page_next  = page_in;
        valid_next = valid_reg;
        claim_next = claim_reg;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                OP_CREATE:
                begin
                    if (overlaps)
                    begin
                        tok_next.trap = 1'b1;
                    end
                    if (!valid_reg && !tok_in.found)
                    begin
                        tok_next.found = 1'b1;
                        claim_next     = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (!tok_in.trap && !tok_in.found && valid_reg && start_reg == req_page)
                    begin
                        tok_next.found = 1'b1;
                        valid_next     = 1'b0;
                    end
                end
                OP_LOOKUP:
                begin
                    if (!tok_in.found && contains)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.acc   = acc_reg;
                        page_next      = start_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmt.write && claim_reg)
        begin
            valid_next = 1'b1;
        end
        if (cmt.release_claim)
        begin
            claim_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        if (cmt.write && claim_reg)
        begin
            start_reg <= req_page;
            end_reg   <= req_end;
            acc_reg   <= req_acc;
        end
    end

    assign tok_out  = tok_reg;
    assign page_out = page_reg;
    assign claimed  = claim_reg;

endmodule

FILE: rtl/segment_region_table_unit.sv
// ----------------------------------------------------------------------------
// segment_region_table_unit
// Table of virtual memory segments with create, delete and lookup requests.
// ----------------------------------------------------------------------------
// Usage: a request transaction (opcode, start_address, page_count,
// access_kind) is taken on the in channel when in_valid is high and in_stall
// is low. Every request produces exactly one result transaction (status,
// hit_access, hit_start_page) on the out channel, taken when out_valid is
// high and out_stall is low.
// A request token walks the row of MAX_SEGMENTS slot cells, one cell per
// cycle: it is registered at the row's entry, then in each cell in turn,
// and its result is registered on the out channel or parked behind it. No
// new request is taken until the walk of the last one has ended.
// in_stall is high while a walk is under way and while a finished result is
// parked behind an output that the receiver is stalling; one result may wait
// on the out channel while the next request walks the row.
// Reset empties the table and drops any request in flight; no clearing pass
// is needed, the block takes requests from the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_region_table_unit
    import srt_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int PAGE_BITS    = PAGE_BITS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    localparam int PAGE_W      = ADDR_BITS - PAGE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [ADDR_BITS-1:0] start_address,
    input  logic [PAGE_W-1:0]    page_count,
    input  logic [ACC_W-1:0]     access_kind,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [ACC_W-1:0]     hit_access,
    output logic [PAGE_W-1:0]    hit_start_page
);

    tok_t              tok_chain  [0:MAX_SEGMENTS];
    logic [PAGE_W-1:0] page_chain [0:MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] tok_live;
    logic [MAX_SEGMENTS-1:0] claim_vec;

    logic              accept;
    logic [PAGE_W-1:0] addr_page;
    logic              misaligned;
    logic [PAGE_W:0]   end_sum;
    logic              trap_init;

    tok_t              tok0_reg;
    logic              busy_reg;
    logic [PAGE_W-1:0] req_page_reg;
    logic [PAGE_W-1:0] req_end_reg;
    logic [ACC_W-1:0]  req_acc_reg;

    tok_t              last;
    logic              finish;
    logic              res_status;
    cmt_t              cmt;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic              out_free;
    logic              load_out_from_res;
    logic              load_out_from_pend;
    logic              out_status_reg;
    logic [ACC_W-1:0]  out_acc_reg;
    logic [PAGE_W-1:0] out_page_reg;
    logic              pend_status_reg;
    logic [ACC_W-1:0]  pend_acc_reg;
    logic [PAGE_W-1:0] pend_page_reg;

    assign in_stall = busy_reg || pend_valid_reg;
    assign accept   = in_valid && !in_stall;

    assign addr_page  = start_address[ADDR_BITS-1:PAGE_BITS];
    assign misaligned = |start_address[PAGE_BITS-1:0];
    assign end_sum    = {1'b0, addr_page} + {1'b0, page_count};

    // Checks that need no table contents are settled before the walk.
    always_comb
    begin
        unique case (opcode)
            OP_CREATE: trap_init = misaligned || end_sum[PAGE_W];
            OP_DELETE: trap_init = misaligned;
            OP_LOOKUP: trap_init = 1'b0;
            default:   trap_init = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            tok0_reg.valid <= accept;
            tok0_reg.op    <= opcode;
            tok0_reg.trap  <= trap_init;
            tok0_reg.found <= 1'b0;
            tok0_reg.acc   <= '0;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_page_reg <= addr_page;
            req_end_reg  <= end_sum[PAGE_W-1:0];
            req_acc_reg  <= access_kind;
        end
    end

    assign tok_chain[0]  = tok0_reg;
    assign page_chain[0] = '0;

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        srt_cell #(
            .PAGE_W (PAGE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok_chain[i]),
            .page_in  (page_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .page_out (page_chain[i+1]),
            .req_page (req_page_reg),
            .req_end  (req_end_reg),
            .req_acc  (req_acc_reg),
            .cmt      (cmt),
            .claimed  (claim_vec[i])
        );
        assign tok_live[i] = tok_chain[i+1].valid;
    end

    assign last       = tok_chain[MAX_SEGMENTS];
    assign finish     = last.valid;
    // Status is set on any trap, and also when create finds no free slot,
    // delete no matching start, or lookup no segment holding the address.
    assign res_status = last.trap || !last.found;

    assign cmt.write         = finish && (last.op == OP_CREATE) && !last.trap && last.found;
    assign cmt.release_claim = finish;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        pend_valid_next    = pend_valid_reg;
        load_out_from_res  = 1'b0;
        load_out_from_pend = 1'b0;
        if (finish)
        begin
            if (out_free)
            begin
                out_valid_next    = 1'b1;
                load_out_from_res = 1'b1;
            end
            else
            begin
                pend_valid_next = 1'b1;
            end
        end
        else if (pend_valid_reg && out_free)
        begin
            out_valid_next     = 1'b1;
            pend_valid_next    = 1'b0;
            load_out_from_pend = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_from_res)
        begin
            out_status_reg <= res_status;
            out_acc_reg    <= last.acc;
            out_page_reg   <= page_chain[MAX_SEGMENTS];
        end
        else if (load_out_from_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_acc_reg    <= pend_acc_reg;
            out_page_reg   <= pend_page_reg;
        end
        if (finish && !out_free)
        begin
            pend_status_reg <= res_status;
            pend_acc_reg    <= last.acc;
            pend_page_reg   <= page_chain[MAX_SEGMENTS];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign hit_access     = out_acc_reg;
    assign hit_start_page = out_page_reg;

    `ASSERT_IMP(a_single_token, clk, rst_n, 1'b1, $countones(tok_live) <= 1)
    `ASSERT_IMP(a_token_in_walk, clk, rst_n, finish, busy_reg)
    `ASSERT_IMP(a_write_on_create, clk, rst_n, cmt.write, last.op == OP_CREATE)
    `ASSERT_IMP(a_claim_single, clk, rst_n, 1'b1, $onehot0(claim_vec))
    `ASSERT_IMP(a_pend_behind_out, clk, rst_n, pend_valid_reg, out_valid_reg)

endmodule

FILE: sim/segment_region_table_unit_tb.sv
// ----------------------------------------------------------------------------
// segment_region_table_unit_tb
// Self-checking testbench for the segment region table. A shadow copy of the
// table predicts the status and hit fields of every request transaction, and
// each result transaction is compared with the oldest prediction. Directed
// requests cover alignment, range, overlap, zero-length and full-table cases;
// random traffic with idling, a receiver hold-off and noise follows.
// ----------------------------------------------------------------------------
module segment_region_table_unit_tb;
    import srt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = ADDR_BITS_DEF;
    localparam int PAGE_W      = ADDR_BITS_DEF - PAGE_BITS_DEF;
    localparam int SLOTS       = MAX_SEGMENTS_DEF;
    localparam int WALK_CYCLES = MAX_SEGMENTS_DEF + 2;
    localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_BITS_DEF;
    localparam longint unsigned ADDR_LIMIT = 64'd1 << ADDR_BITS_DEF;

    localparam logic [OP_W-1:0]  OP_UNDEF       = 2'd3;
    localparam logic [ACC_W-1:0] ACC_READ       = 2'd0;
    localparam logic [ACC_W-1:0] ACC_WRITE      = 2'd1;
    localparam logic [ACC_W-1:0] ACC_READ_WRITE = 2'd2;
    localparam logic [ACC_W-1:0] ACC_EXECUTE    = 2'd3;
    localparam logic             ST_OK          = 1'b0;
    localparam logic             ST_TRAP        = 1'b1;

    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic              status;
        logic [ACC_W-1:0]  acc;
        logic [PAGE_W-1:0] page;
    } seg_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   opcode = '0;
    logic [ADDR_W-1:0] start_address = '0;
    logic [PAGE_W-1:0] page_count = '0;
    logic [ACC_W-1:0]  access_kind = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              status;
    logic [ACC_W-1:0]  hit_access;
    logic [PAGE_W-1:0] hit_start_page;

    // Shadow copy of the segment table.
    logic              seg_valid [SLOTS];
    logic [PAGE_W-1:0] seg_first_page [SLOTS];
    logic [PAGE_W-1:0] seg_len [SLOTS];
    logic [ACC_W-1:0]  seg_acc [SLOTS];

    seg_result_t expected_results[$];
    int          error_count = 0;
    bit          quiet = 1'b0;
    bit          hold_off_request = 1'b0;
    int          hold_left = 0;

    segment_region_table_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .start_address  (start_address),
        .page_count     (page_count),
        .access_kind    (access_kind),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .hit_access     (hit_access),
        .hit_start_page (hit_start_page)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Applies one request to the shadow table and returns the result it gives.
    function automatic seg_result_t apply_segment_request(
        logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
        logic [PAGE_W-1:0] cnt, logic [ACC_W-1:0] kind);
        seg_result_t       res;
        longint unsigned   a;
        longint unsigned   new_hi;
        longint unsigned   seg_lo;
        longint unsigned   seg_hi;
        int                free_slot;
        bit                blocked;
        bit                done;
        res       = '{status: ST_TRAP, acc: '0, page: '0};
        a         = longint'(addr);
        new_hi    = a + longint'(cnt) * PAGE_BYTES;
        free_slot = -1;
        done      = 1'b0;
        case (op)
            OP_CREATE:
            begin
                blocked = (a % PAGE_BYTES != 0) || (new_hi >= ADDR_LIMIT);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (seg_valid[i])
                    begin
                        seg_lo = longint'(seg_first_page[i]) << PAGE_BITS_DEF;
                        seg_hi = seg_lo + longint'(seg_len[i]) * PAGE_BYTES;
                        if ((seg_lo <= a && seg_hi > a) || (a <= seg_lo && new_hi > seg_lo))
                            blocked = 1'b1;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (!blocked && free_slot >= 0)
                begin
                    seg_valid[free_slot]      = 1'b1;
                    seg_first_page[free_slot] = addr[ADDR_W-1:PAGE_BITS_DEF];
                    seg_len[free_slot]        = cnt;
                    seg_acc[free_slot]        = kind;
                    res.status                = ST_OK;
                end
            end
            OP_DELETE:
            begin
                if (a % PAGE_BYTES == 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!done && seg_valid[i] &&
                            (longint'(seg_first_page[i]) << PAGE_BITS_DEF) == a)
                        begin
                            seg_valid[i] = 1'b0;
                            res.status   = ST_OK;
                            done         = 1'b1;
                        end
                    end
                end
            end
            OP_LOOKUP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    seg_lo = longint'(seg_first_page[i]) << PAGE_BITS_DEF;
                    seg_hi = seg_lo + longint'(seg_len[i]) * PAGE_BYTES;
                    if (!done && seg_valid[i] && seg_lo <= a && seg_hi > a)
                    begin
                        res  = '{status: ST_OK, acc: seg_acc[i], page: seg_first_page[i]};
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Picks a random occupied slot, or -1 when the table is empty.
    function automatic int pick_live_slot();
        int live[$];
        for (int i = 0; i < SLOTS; i++)
            if (seg_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Offers one request and returns once it has been taken.
    task automatic issue_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [PAGE_W-1:0] cnt, logic [ACC_W-1:0] kind);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        opcode        <= op;
        start_address <= addr;
        page_count    <= cnt;
        access_kind   <= kind;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_results.push_back(apply_segment_request(op, addr, cnt, kind));
    endtask

    // Mostly well-formed requests around the stored segments, with some noise.
    task automatic issue_random_request();
        int                slot;
        int                pick;
        logic [PAGE_W-1:0] pg;
        longint unsigned   base;
        pick = $urandom_range(0, 99);
        slot = pick_live_slot();
        pg   = ($urandom_range(0, 1) != 0) ? PAGE_W'($urandom_range(0, 63))
                                           : PAGE_W'(32767 - $urandom_range(0, 63));
        if (pick < 40)
        begin
            issue_request(OP_CREATE, {pg, {PAGE_BITS_DEF{1'b0}}},
                          PAGE_W'($urandom_range(0, 6)), ACC_W'($urandom_range(0, 3)));
        end
        else if (pick < 60)
        begin
            if (slot >= 0 && $urandom_range(0, 3) != 0)
                pg = seg_first_page[slot];
            issue_request(OP_DELETE, {pg, {PAGE_BITS_DEF{1'b0}}},
                          PAGE_W'($urandom), ACC_W'($urandom));
        end
        else if (pick < 88)
        begin
            if (slot >= 0 && $urandom_range(0, 4) != 0)
            begin
                base = longint'(seg_first_page[slot]) << PAGE_BITS_DEF;
                base = base + $urandom_range(0, int'(seg_len[slot]) * int'(PAGE_BYTES));
                issue_request(OP_LOOKUP, ADDR_W'(base), PAGE_W'($urandom),
                              ACC_W'($urandom));
            end
            else
            begin
                issue_request(OP_LOOKUP, {pg, PAGE_BITS_DEF'($urandom)},
                              PAGE_W'($urandom), ACC_W'($urandom));
            end
        end
        else
        begin
            issue_request(OP_W'($urandom_range(0, 3)), ADDR_W'($urandom),
                          PAGE_W'($urandom), ACC_W'($urandom));
        end
    endtask

    // Receiver: random stalls, a quiet mode, and a long counted hold-off.
    always @(negedge clk)
    begin
        if (hold_off_request)
        begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 14);
        end
    end

    always @(posedge clk)
    begin
        seg_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result transaction with nothing expected", $realtime);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || hit_access !== want.acc ||
                    hit_start_page !== want.page)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $realtime, want.status, want.acc, want.page,
                                 status, hit_access, hit_start_page);
                end
            end
        end
    end

    task automatic test_directed();
        logic [ADDR_W-1:0] last_page;
        last_page = ADDR_W'(ADDR_LIMIT - PAGE_BYTES);
        issue_request(OP_CREATE, 25'd0, 15'd4, ACC_READ);
        issue_request(OP_LOOKUP, 25'd0, 15'd0, ACC_READ);
        issue_request(OP_LOOKUP, 25'd4095, 15'd0, ACC_READ);
        // The first byte past a segment does not belong to it.
        issue_request(OP_LOOKUP, 25'd4096, 15'd0, ACC_READ);
        issue_request(OP_CREATE, 25'd2048, 15'd4, ACC_WRITE);
        issue_request(OP_CREATE, 25'd4096, 15'd2, ACC_WRITE);
        issue_request(OP_CREATE, 25'd102401, 15'd1, ACC_WRITE);
        issue_request(OP_CREATE, last_page, 15'd1, ACC_EXECUTE);
        // Two zero-length segments at the same start may coexist.
        issue_request(OP_CREATE, last_page, 15'd0, ACC_EXECUTE);
        issue_request(OP_CREATE, last_page, 15'd0, ACC_READ_WRITE);
        issue_request(OP_LOOKUP, last_page, 15'd0, ACC_READ);
        issue_request(OP_DELETE, last_page, 15'd0, ACC_READ);
        issue_request(OP_DELETE, last_page, 15'd0, ACC_READ);
        issue_request(OP_DELETE, last_page, 15'd0, ACC_READ);
        issue_request(OP_DELETE, last_page + 25'd1, 15'd0, ACC_READ);
        issue_request(OP_CREATE, 25'd8192, 15'h7FFF, ACC_READ);
        issue_request(OP_CREATE, 25'd20480, 15'd10, ACC_READ_WRITE);
        // A new segment that swallows the start of a stored one.
        issue_request(OP_CREATE, 25'd15360, 15'd10, ACC_READ);
        issue_request(OP_UNDEF, 25'h1FFFFFF, 15'h7FFF, ACC_EXECUTE);
        issue_request(OP_LOOKUP, 25'h1FFFFFF, 15'h7FFF, ACC_EXECUTE);
        issue_request(OP_DELETE, 25'd0, 15'd0, ACC_READ);
        issue_request(OP_DELETE, 25'd4096, 15'd0, ACC_READ);
        issue_request(OP_DELETE, 25'd20480, 15'd0, ACC_READ);
        issue_request(OP_CREATE, 25'd0, 15'h7FFF, ACC_EXECUTE);
        issue_request(OP_LOOKUP, ADDR_W'(longint'(15'h7FFF) * PAGE_BYTES - 1), 15'd0, ACC_READ);
        issue_request(OP_DELETE, 25'd0, 15'd0, ACC_READ);
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= SLOTS; i++)
            issue_request(OP_CREATE, ADDR_W'((100 + 2 * i) * int'(PAGE_BYTES)), 15'd1,
                          ACC_W'($urandom_range(0, 3)));
        issue_request(OP_LOOKUP, ADDR_W'(110 * int'(PAGE_BYTES) + 5), 15'd0, ACC_READ);
        issue_request(OP_DELETE, ADDR_W'(110 * int'(PAGE_BYTES)), 15'd0, ACC_READ);
        // The freed slot is taken again by the next create.
        issue_request(OP_CREATE, ADDR_W'(300 * int'(PAGE_BYTES)), 15'd3, ACC_EXECUTE);
        issue_request(OP_LOOKUP, ADDR_W'(302 * int'(PAGE_BYTES)), 15'd0, ACC_READ);
        for (int i = 0; i < SLOTS; i++)
            if (seg_valid[i])
                issue_request(OP_DELETE, {seg_first_page[i], {PAGE_BITS_DEF{1'b0}}},
                              15'd0, ACC_READ);
    endtask

    task automatic test_output_hold_off();
        hold_off_request = 1'b1;
        for (int i = 0; i < 10; i++)
            issue_random_request();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 250 && n < 350);
            issue_random_request();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            seg_valid[i]      = 1'b0;
            seg_first_page[i] = '0;
            seg_len[i]        = '0;
            seg_acc[i]        = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_output_hold_off();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * WALK_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
